// ----- rtl/sdrs_pkg.sv -----
package sdrs_pkg;

  // Input transaction
  typedef struct packed {
    logic        op;
    logic [15:0] req_id;
    logic [31:0] arrival_time;
    logic [15:0] req_cylinder;
    logic [31:0] req_address;
    logic [15:0] proc_id;
    logic [15:0] head_cylinder;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic [15:0] serving_id;
    logic [31:0] serving_time;
    logic [15:0] serving_cylinder;
    logic [31:0] serving_address;
    logic [15:0] serving_process;
    logic        idle;
    logic        dropped;
    logic [4:0]  queue_count;
  } res_t;

  // One stored request
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] time_stamp;
    logic [15:0] cyl;
    logic [31:0] addr;
    logic [15:0] proc;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  localparam logic OP_ARRIVAL = 1'b0;

  // Datapath actions
  typedef enum logic [2:0] {
    A_NOP,
    A_SCAN_INIT,
    A_SCAN,
    A_TAKE,
    A_SHIFT,
    A_FINISH,
    A_ARRIVE,
    A_CLEAR
  } act_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_START,
    C_ARRIVAL,
    C_EMPTY,
    C_MORE
  } cond_t;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  // Microprogram step addresses
  localparam upc_t U_WAIT   = 4'd0;
  localparam upc_t U_DECODE = 4'd1;
  localparam upc_t U_CHECK  = 4'd2;
  localparam upc_t U_SCAN   = 4'd3;
  localparam upc_t U_TAKE   = 4'd4;
  localparam upc_t U_SHIFT  = 4'd5;
  localparam upc_t U_FINISH = 4'd6;
  localparam upc_t U_ARRIVE = 4'd7;
  localparam upc_t U_CLEAR  = 4'd8;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic is_arrival;
    logic q_empty;
    logic more;
  } dp_stat_t;

  // Microcode ROM
  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    w = '{act: A_NOP, cond: C_ALWAYS, target: U_WAIT};
    case (a)
      U_WAIT:   w = '{act: A_NOP,       cond: C_NOT_START, target: U_WAIT};
      U_DECODE: w = '{act: A_SCAN_INIT, cond: C_ARRIVAL,   target: U_ARRIVE};
      U_CHECK:  w = '{act: A_NOP,       cond: C_EMPTY,     target: U_CLEAR};
      U_SCAN:   w = '{act: A_SCAN,      cond: C_MORE,      target: U_SCAN};
      U_TAKE:   w = '{act: A_TAKE,      cond: C_NEVER,     target: U_WAIT};
      U_SHIFT:  w = '{act: A_SHIFT,     cond: C_MORE,      target: U_SHIFT};
      U_FINISH: w = '{act: A_FINISH,    cond: C_ALWAYS,    target: U_WAIT};
      U_ARRIVE: w = '{act: A_ARRIVE,    cond: C_ALWAYS,    target: U_WAIT};
      U_CLEAR:  w = '{act: A_CLEAR,     cond: C_ALWAYS,    target: U_WAIT};
      default:  w = '{act: A_NOP,       cond: C_ALWAYS,    target: U_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/sdrs_ram.sv -----
module sdrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sdrs_useq.sv -----
module sdrs_useq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  sdrs_pkg::dp_stat_t stat,
  output sdrs_pkg::act_t     act,
  output logic               busy
);
  import sdrs_pkg::*;

  upc_t   upc_r, upc_nxt;
  uword_t uw;
  logic   take_jump;

  assign uw   = ucode(upc_r);
  assign act  = uw.act;
  assign busy = (upc_r != U_WAIT);

  always_comb begin
    case (uw.cond)
      C_NEVER:     take_jump = 1'b0;
      C_ALWAYS:    take_jump = 1'b1;
      C_NOT_START: take_jump = !start;
      C_ARRIVAL:   take_jump = stat.is_arrival;
      C_EMPTY:     take_jump = stat.q_empty;
      C_MORE:      take_jump = stat.more;
      default:     take_jump = 1'b1;
    endcase
    upc_nxt = take_jump ? uw.target : upc_r + upc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ----- rtl/sdrs_dpath.sv -----
module sdrs_dpath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  sdrs_pkg::req_t     in_req,
  input  sdrs_pkg::act_t     act,
  output sdrs_pkg::dp_stat_t stat,
  output logic               out_valid,
  output sdrs_pkg::res_t     out_res
);
  import sdrs_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_t             req_r;
  rec_t             svc_r, svc_nxt;
  logic             svc_vld_r, svc_vld_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [15:0]      best_dist_r, best_dist_nxt;
  logic [31:0]      best_time_r, best_time_nxt;
  rec_t             best_rec_r, best_rec_nxt;
  res_t             res_r, res_nxt;
  logic             res_vld_r, res_vld_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [REC_W-1:0] ram_wdata;
  logic [REC_W-1:0] ram_rdata;
  rec_t             ram_rec;
  rec_t             new_rec;
  logic [15:0]      cyl_dist;
  logic             better;
  logic             dropped;

  sdrs_ram #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign ram_rec = ram_rdata;
  assign new_rec = '{id: req_r.req_id, time_stamp: req_r.arrival_time,
                     cyl: req_r.req_cylinder, addr: req_r.req_address,
                     proc: req_r.proc_id};

  // |head - cyl| and the ordering rule: nearer wins, then earlier timestamp
  assign cyl_dist = (req_r.head_cylinder >= ram_rec.cyl) ?
                    (req_r.head_cylinder - ram_rec.cyl) :
                    (ram_rec.cyl - req_r.head_cylinder);
  assign better = (cmp_idx_r == '0) || (cyl_dist < best_dist_r) ||
                  ((cyl_dist == best_dist_r) && (ram_rec.time_stamp < best_time_r));

  assign stat.is_arrival = (req_r.op == OP_ARRIVAL);
  assign stat.q_empty    = (cnt_r == '0);
  assign stat.more       = (rd_idx_r != cnt_r);

  always_comb begin
    svc_nxt       = svc_r;
    svc_vld_nxt   = svc_vld_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    pend_nxt      = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    best_idx_nxt  = best_idx_r;
    best_dist_nxt = best_dist_r;
    best_time_nxt = best_time_r;
    best_rec_nxt  = best_rec_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_idx_r;
    ram_wdata     = ram_rdata;
    dropped       = 1'b0;
    res_vld_nxt   = 1'b0;

    case (act)
      A_SCAN_INIT: begin
        rd_idx_nxt = '0;
      end
      A_SCAN: begin
        // read one entry per cycle, compare the one read last cycle
        if (rd_idx_r != cnt_r) begin
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
          pend_nxt    = 1'b1;
        end
        if (pend_r && better) begin
          best_idx_nxt  = cmp_idx_r;
          best_dist_nxt = cyl_dist;
          best_time_nxt = ram_rec.time_stamp;
          best_rec_nxt  = ram_rec;
        end
      end
      A_TAKE: begin
        svc_nxt     = best_rec_r;
        svc_vld_nxt = 1'b1;
        rd_idx_nxt  = CNT_W'(best_idx_r) + CNT_W'(1);
        wr_idx_nxt  = best_idx_r;
      end
      A_SHIFT: begin
        // close the gap: entry i+1 moves to i
        if (rd_idx_r != cnt_r) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
          pend_nxt   = 1'b1;
        end
        if (pend_r) begin
          ram_we     = 1'b1;
          wr_idx_nxt = wr_idx_r + IDX_W'(1);
        end
      end
      A_FINISH: begin
        cnt_nxt     = cnt_r - CNT_W'(1);
        res_vld_nxt = 1'b1;
      end
      A_ARRIVE: begin
        if (!svc_vld_r) begin
          svc_nxt     = new_rec;
          svc_vld_nxt = 1'b1;
        end else if (cnt_r < CNT_W'(QUEUE_DEPTH)) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r[IDX_W-1:0];
          ram_wdata = new_rec;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end else begin
          dropped = 1'b1;
        end
        res_vld_nxt = 1'b1;
      end
      A_CLEAR: begin
        svc_nxt     = '0;
        svc_vld_nxt = 1'b0;
        res_vld_nxt = 1'b1;
      end
      default: begin
      end
    endcase

    res_nxt.serving_id       = svc_vld_nxt ? svc_nxt.id         : '0;
    res_nxt.serving_time     = svc_vld_nxt ? svc_nxt.time_stamp : '0;
    res_nxt.serving_cylinder = svc_vld_nxt ? svc_nxt.cyl        : '0;
    res_nxt.serving_address  = svc_vld_nxt ? svc_nxt.addr       : '0;
    res_nxt.serving_process  = svc_vld_nxt ? svc_nxt.proc       : '0;
    res_nxt.idle             = !svc_vld_nxt;
    res_nxt.dropped          = dropped;
    res_nxt.queue_count      = 5'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      svc_vld_r <= 1'b0;
      cnt_r     <= '0;
      pend_r    <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      svc_vld_r <= svc_vld_nxt;
      cnt_r     <= cnt_nxt;
      pend_r    <= pend_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_r <= in_req;
    end
    svc_r       <= svc_nxt;
    rd_idx_r    <= rd_idx_nxt;
    wr_idx_r    <= wr_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
    best_time_r <= best_time_nxt;
    best_rec_r  <= best_rec_nxt;
    res_r       <= res_nxt;
  end

  assign out_valid = res_vld_r;
  assign out_res   = res_r;

endmodule

// ----- rtl/sstf_disk_request_scheduler.sv -----
// Shortest-seek-time-first disk request scheduler. A transaction is taken when
// start is high and busy is low; every transaction gives exactly one result,
// shown for one cycle with out_valid, which the receiver cannot stall. The
// time a completion with queued requests takes is set by the queue RAM, which
// has one read port and one write port: the nearest-cylinder scan reads one
// entry per cycle, and closing the gap left by the chosen entry moves one
// entry per cycle. The result strobe lands in the cycle in which busy drops,
// so the next transaction can be taken there.
module sstf_disk_request_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  sdrs_pkg::req_t in_req,
  output logic           out_valid,
  output sdrs_pkg::res_t out_res
);
  import sdrs_pkg::*;

  act_t     act;
  dp_stat_t stat;
  logic     load;

  // transaction accepted at this edge
  assign load = start && !busy;

  // microcode sequencer: step counter, control ROM, conditional jumps
  sdrs_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .act   (act),
    .busy  (busy)
  );

  // datapath: request latch, in-service record, queue RAM, scan/compact
  // pointers, best-candidate registers and the result register
  sdrs_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .in_req    (in_req),
    .act       (act),
    .stat      (stat),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

// ----- rtl/sdrs_checker.sv -----
module sdrs_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input sdrs_pkg::res_t out_res,
  input logic           out_valid
);

  // accepted transaction keeps the block busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after accepted transaction");

  // one result per transaction: strobes never back to back
  a_no_double_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe in consecutive cycles");

  // idle result carries the null record
  a_idle_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.idle) |->
      (out_res.serving_id == 16'd0 && out_res.serving_time == 32'd0 &&
       out_res.serving_cylinder == 16'd0 && out_res.serving_address == 32'd0 &&
       out_res.serving_process == 16'd0 && !out_res.dropped))
    else $error("idle result with nonzero record");

  // drop only when busy and the queue is full
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.dropped) |->
      (!out_res.idle && out_res.queue_count == 5'(QUEUE_DEPTH)))
    else $error("drop without full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((QUEUE_DEPTH > 31) || (32'(out_res.queue_count) <= QUEUE_DEPTH)))
    else $error("queue count above depth");

endmodule

bind sstf_disk_request_scheduler sdrs_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_sdrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_res   (out_res),
  .out_valid (out_valid)
);
